>>> design/mwg_pkg.sv
// Shared types, codes, constants and the quarter-wave sine table of the waveform generator.
package mwg_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int FRAC_BITS      = SAMPLE_BITS - 1;
	localparam int SINE_DEPTH     = 256;
	localparam int SINE_ADDR_BITS = 8;
	localparam int SINE_VAL_BITS  = FRAC_BITS;

	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SAWTOOTH = 2'd3
	} wave_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_AM   = 2'd1,
		MODE_FM   = 2'd2,
		MODE_PWM  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_WAVE_SELECT  = 3'd0,
		REG_MOD_MODE     = 3'd1,
		REG_BASE_STEP    = 3'd2,
		REG_BASE_AMP     = 3'd3,
		REG_SHAPE_PARAM  = 3'd4,
		REG_CARRIER_STEP = 3'd5,
		REG_CARRIER_AMP  = 3'd6,
		REG_MOD_INDEX    = 3'd7
	} cfg_reg_t;

	typedef logic [SINE_VAL_BITS-1:0] sine_rom_t [0:SINE_DEPTH];

	// Entry k holds round((ONE-1) * sin(pi/2 * k/DEPTH)), from a Q30 Taylor series.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint unsigned xv;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			xv   = (Q30_HALF_PI * 64'(k)) / SINE_DEPTH;
			x2   = (xv * xv) >> 30;
			term = xv;
			sum  = longint'(xv);
			term = ((term * x2) >> 30) / 6;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 20;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 42;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 72;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 110;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 156;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 210;
			sum  = sum - longint'(term);
			if (sum < 0) sum = 0;
			if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
			rom[k] = SINE_VAL_BITS'((sum * ((64'sd1 <<< FRAC_BITS) - 1) + (64'sd1 <<< 29)) >>> 30);
		end
		return rom;
	endfunction

endpackage

>>> design/modulated_waveform_generator_top.sv
// Top level of the DDS waveform generator with AM, FM and PWM modulation.
//
// Each request on the s_ side is one sample tick: bit 0 of s_tdata set clears both
// phase accumulators before the sample is formed. One result per tick leaves on the
// m_ side, with the saturated Q1.15 sample in m_tdata and the clip flag in m_tuser.
// All multiplication goes through a single registered 18x18 multiplier that a small
// sequencer reuses, and the input is not ready while a tick is being worked on.
// How long a tick takes is set by how many products the mode chains through that
// multiplier: one when unmodulated or in PWM, two in FM and three in AM, each with
// an operand and a product register.
// The result waits in an output register, so the next tick is taken while it is unread;
// a tick finishing before the previous result is read holds until it is.
// Registers are written through the cfg_ port, which is always ready; write them only
// while no tick is in flight.
module modulated_waveform_generator_top
	import mwg_pkg::*;
#(
	parameter int PHASE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] sample
	output logic [0:0]  m_tuser,    // [0] clipped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WAVE,
		S_MUL_ENV,
		S_ENV,
		S_MUL_LVL,
		S_LVL,
		S_FM_SIN,
		S_MUL_OUT,
		S_OUT
	} state_t;

	localparam int TRI_R = (PHASE_BITS >= FRAC_BITS + 2) ? PHASE_BITS - FRAC_BITS - 2 : 0;
	localparam int TRI_L = (PHASE_BITS <  FRAC_BITS + 2) ? FRAC_BITS + 2 - PHASE_BITS : 0;
	localparam int SAW_R = (PHASE_BITS >= FRAC_BITS + 1) ? PHASE_BITS - FRAC_BITS - 1 : 0;
	localparam int SAW_L = (PHASE_BITS <  FRAC_BITS + 1) ? FRAC_BITS + 1 - PHASE_BITS : 0;
	localparam int FM_E  = PHASE_BITS - 16 - FRAC_BITS;
	localparam int FM_L  = (FM_E > 0) ? FM_E : 0;
	localparam int FM_R  = (FM_E < 0) ? -FM_E : 0;
	localparam logic signed [63:0] FM_RND = (64'sd1 <<< FM_R) >>> 1;

	localparam logic signed [FRAC_BITS+1:0] X_ONE   = (FRAC_BITS + 2)'(1 << FRAC_BITS);
	localparam logic signed [FRAC_BITS+3:0] X_THREE = (FRAC_BITS + 4)'(3 << FRAC_BITS);
	localparam logic signed [17:0]          M_ONE   = 18'(1 << FRAC_BITS);
	localparam logic signed [35:0]          M_HALF  = 36'(1 << (FRAC_BITS - 1));
	localparam logic signed [20:0]          Y_MAX   = 21'((1 << FRAC_BITS) - 1);
	localparam logic signed [20:0]          Y_MIN   = -21'(1 << FRAC_BITS);

	state_t state_q;

	wave_t                   wave_select_q;
	mode_t                   mod_mode_q;
	logic [31:0]             base_step_q;
	logic [14:0]             base_amp_q;
	logic [15:0]             shape_param_q;
	logic [31:0]             carrier_step_q;
	logic [14:0]             carrier_amp_q;
	logic [15:0]             mod_index_q;
	logic [PHASE_BITS-1:0]   base_phase_q;
	logic [PHASE_BITS-1:0]   carrier_phase_q;
	logic [SAMPLE_BITS-1:0]  sample_q;
	logic                    clipped_q;
	logic                    m_tvalid_q;

	logic signed [17:0]      mul_a_q;
	logic signed [17:0]      mul_b_q;
	logic signed [35:0]      prod_q;
	logic [PHASE_BITS-1:0]   fm_phase_q;

	logic [PHASE_BITS-1:0]       shape_off;
	logic [PHASE_BITS-1:0]       sin_phase;
	logic signed [SAMPLE_BITS-1:0] sin_val;
	logic [PHASE_BITS+1:0]       tri_w;
	logic [PHASE_BITS+1:0]       saw_w;
	logic [PHASE_BITS+1:0]       ramp_w;
	logic [FRAC_BITS+1:0]        tri_pos;
	logic signed [FRAC_BITS+3:0] tri_full;
	logic signed [FRAC_BITS+1:0] x_val;
	logic signed [FRAC_BITS+1:0] ramp_val;
	logic signed [35:0]          prod_sum;
	logic signed [20:0]          rnd;
	logic signed [20:0]          env_w;
	logic signed [63:0]          fm_sh;
	logic [PHASE_BITS-1:0]       fm_off;
	logic [SAMPLE_BITS-1:0]      sat_val;
	logic                        sat_clip;
	logic                        in_take;
	logic                        out_load;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = sample_q;
	assign m_tuser   = clipped_q;

	assign in_take  = s_tvalid && s_tready;
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	assign shape_off = PHASE_BITS'(shape_param_q) << (PHASE_BITS - 16);

	always_comb begin
		case (state_q)
			S_WAVE:   sin_phase = base_phase_q + shape_off;
			S_FM_SIN: sin_phase = fm_phase_q;
			default:  sin_phase = carrier_phase_q;
		endcase
	end

	mwg_sine #(
		.PHASE_BITS(PHASE_BITS)
	) u_sine (
		.phase(sin_phase),
		.value(sin_val)
	);

	// Base waveform, normalized to [-ONE, ONE], and the carrier ramp used by PWM.
	always_comb begin
		tri_w    = ({2'b00, base_phase_q} >> TRI_R) << TRI_L;
		saw_w    = ({2'b00, base_phase_q} >> SAW_R) << SAW_L;
		ramp_w   = ({2'b00, carrier_phase_q} >> SAW_R) << SAW_L;
		tri_pos  = tri_w[FRAC_BITS+1:0];
		ramp_val = $signed({1'b0, ramp_w[FRAC_BITS:0]}) - X_ONE;
		if (!tri_pos[FRAC_BITS+1]) begin
			tri_full = $signed({2'b00, tri_pos}) - (FRAC_BITS + 4)'(X_ONE);
		end else begin
			tri_full = X_THREE - $signed({2'b00, tri_pos});
		end
		case (wave_select_q)
			WAVE_SINE:     x_val = (FRAC_BITS + 2)'(sin_val);
			WAVE_SQUARE:   x_val = (base_phase_q < shape_off) ? X_ONE : -X_ONE;
			WAVE_TRIANGLE: x_val = tri_full[FRAC_BITS+1:0];
			default:       x_val = $signed({1'b0, saw_w[FRAC_BITS:0]}) - X_ONE;
		endcase
		if (wave_select_q != WAVE_SINE && base_step_q == '0) begin
			x_val = '0;
		end
		if (mod_mode_q != MODE_NONE && base_amp_q == '0) begin
			x_val = '0;
		end
	end

	// Product rounding, AM envelope, FM phase offset and output saturation.
	always_comb begin
		prod_sum = prod_q + M_HALF;
		rnd      = prod_sum[35:FRAC_BITS];
		env_w    = rnd + 21'(M_ONE);
		fm_sh    = ((64'(prod_q) + FM_RND) >>> FM_R) <<< FM_L;
		fm_off   = fm_sh[PHASE_BITS-1:0];
		if (rnd > Y_MAX) begin
			sat_val  = Y_MAX[SAMPLE_BITS-1:0];
			sat_clip = 1'b1;
		end else if (rnd < Y_MIN) begin
			sat_val  = Y_MIN[SAMPLE_BITS-1:0];
			sat_clip = 1'b1;
		end else begin
			sat_val  = rnd[SAMPLE_BITS-1:0];
			sat_clip = 1'b0;
		end
	end

	// Shared multiplier and its operand registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a_q * mul_b_q;
		case (state_q)
			S_WAVE: begin
				case (mod_mode_q)
					MODE_NONE: begin
						mul_a_q <= 18'(x_val);
						mul_b_q <= $signed({3'b000, base_amp_q});
					end
					MODE_PWM: begin
						mul_a_q <= (x_val > ramp_val) ? M_ONE : -M_ONE;
						mul_b_q <= $signed({3'b000, carrier_amp_q});
					end
					default: begin
						mul_a_q <= $signed({2'b00, mod_index_q});
						mul_b_q <= 18'(x_val);
					end
				endcase
			end
			S_ENV: begin
				mul_a_q    <= $signed({3'b000, carrier_amp_q});
				mul_b_q    <= env_w[17:0];
				fm_phase_q <= carrier_phase_q + fm_off;
			end
			S_LVL: begin
				mul_a_q <= rnd[17:0];
				mul_b_q <= 18'(sin_val);
			end
			S_FM_SIN: begin
				mul_a_q <= $signed({3'b000, carrier_amp_q});
				mul_b_q <= 18'(sin_val);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			wave_select_q   <= WAVE_SINE;
			mod_mode_q      <= MODE_NONE;
			base_step_q     <= 32'd65536;
			base_amp_q      <= 15'd32767;
			shape_param_q   <= '0;
			carrier_step_q  <= '0;
			carrier_amp_q   <= 15'd32767;
			mod_index_q     <= 16'd16384;
			base_phase_q    <= '0;
			carrier_phase_q <= '0;
			sample_q        <= '0;
			clipped_q       <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WAVE_SELECT:  wave_select_q  <= wave_t'(cfg_data[1:0]);
					REG_MOD_MODE:     mod_mode_q     <= mode_t'(cfg_data[1:0]);
					REG_BASE_STEP:    base_step_q    <= cfg_data;
					REG_BASE_AMP:     base_amp_q     <= cfg_data[14:0];
					REG_SHAPE_PARAM:  shape_param_q  <= cfg_data[15:0];
					REG_CARRIER_STEP: carrier_step_q <= cfg_data;
					REG_CARRIER_AMP:  carrier_amp_q  <= cfg_data[14:0];
					REG_MOD_INDEX:    mod_index_q    <= cfg_data[15:0];
					default: begin
					end
				endcase
			end

			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (s_tdata[0]) begin
							base_phase_q    <= '0;
							carrier_phase_q <= '0;
						end
						state_q <= S_WAVE;
					end
				end
				S_WAVE: begin
					if (mod_mode_q == MODE_AM || mod_mode_q == MODE_FM) begin
						state_q <= S_MUL_ENV;
					end else begin
						state_q <= S_MUL_OUT;
					end
				end
				S_MUL_ENV: state_q <= S_ENV;
				S_ENV: begin
					if (mod_mode_q == MODE_AM) begin
						state_q <= S_MUL_LVL;
					end else begin
						state_q <= S_FM_SIN;
					end
				end
				S_MUL_LVL: state_q <= S_LVL;
				S_LVL:     state_q <= S_MUL_OUT;
				S_FM_SIN:  state_q <= S_MUL_OUT;
				S_MUL_OUT: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						sample_q        <= sat_val;
						clipped_q       <= sat_clip;
						m_tvalid_q      <= 1'b1;
						base_phase_q    <= base_phase_q + PHASE_BITS'(base_step_q);
						carrier_phase_q <= carrier_phase_q + PHASE_BITS'(carrier_step_q);
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Once a tick is taken the block stays busy for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a tick was accepted");

	// A saturated sample sits at one end of the output range.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 16'h7fff || m_tdata == 16'h8000)
		else $error("clip flag set on an unsaturated sample");

	// A new result only appears out of the final sequencer step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");

	// In PWM the sample is always plus or minus the carrier level.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) && mod_mode_q == MODE_PWM |->
			sample_q == {1'b0, carrier_amp_q} || sample_q == -{1'b0, carrier_amp_q})
		else $error("PWM sample is not at a carrier level");

endmodule

>>> design/mwg_sine.sv
// Quarter-wave sine lookup: folds a phase into one quadrant and reads the table.
module mwg_sine
	import mwg_pkg::*;
#(
	parameter int PHASE_BITS = 32
) (
	input  logic [PHASE_BITS-1:0]         phase,
	output logic signed [SAMPLE_BITS-1:0] value
);

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic [1:0]                quad;
	logic [SINE_ADDR_BITS-1:0] addr;
	logic [SINE_ADDR_BITS:0]   idx;
	logic [SINE_VAL_BITS-1:0]  mag;

	assign quad = phase[PHASE_BITS-1 -: 2];
	assign addr = phase[PHASE_BITS-3 -: SINE_ADDR_BITS];

	always_comb begin
		// Odd quadrants run the table backward.
		if (quad[0]) begin
			idx = (SINE_ADDR_BITS + 1)'(SINE_DEPTH) - {1'b0, addr};
		end else begin
			idx = {1'b0, addr};
		end
		mag = SINE_ROM[idx];
		if (quad[1]) begin
			value = -$signed({1'b0, mag});
		end else begin
			value = $signed({1'b0, mag});
		end
	end

endmodule
